// ----- src/pec_pkg.sv -----
package pec_pkg;

    localparam int ENV_GUARD = 4;
    localparam int LOG_FRAC = 16;
    localparam int RATIO_BITS = 13;
    localparam int RATIO_ONE = 256;
    localparam int MANT_W = 31;
    localparam int CONST_W = 30;
    localparam int NUM_CONST = 16;
    localparam int CONST_IDX_W = 4;
    localparam int SQRT_W = 64;
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_CNT_W = 5;
    localparam int PROD_W = 64;
    localparam int REM_W = RATIO_BITS + 1;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int CFG_IDX_W = 2;

    localparam int RST_THRESHOLD = 1056155;
    localparam int RST_RATIO = 768;
    localparam int RST_ATTACK = 655;
    localparam int RST_RELEASE = 6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_RATIO     = 2'd1,
        CFG_ATTACK    = 2'd2,
        CFG_RELEASE   = 2'd3
    } t_cfg_idx;

endpackage

// ----- src/pec_fifo.sv -----
module pec_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0]          r_mem [pec_pkg::QDEPTH];
    logic [pec_pkg::QPTR_W-1:0] r_wp;
    logic [pec_pkg::QPTR_W-1:0] r_rp;
    logic [pec_pkg::QPTR_W:0]   r_cnt;
    logic                       wr_ok;
    logic                       rd_ok;

    assign o_full  = (r_cnt == (pec_pkg::QPTR_W + 1)'(pec_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr_ok && !rd_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- src/pec_front.sv -----
module pec_front #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEFF_BITS = 16,
    parameter int CFG_W = 23
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [pec_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]                       i_cfg_data,
    input  logic                                   i_accept,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample,
    output logic                                   o_bypass,
    output logic [SAMPLE_BITS+pec_pkg::ENV_GUARD-1:0] o_env,
    output logic [SAMPLE_BITS+pec_pkg::ENV_GUARD-1:0] o_thr_e,
    output logic [pec_pkg::RATIO_BITS-1:0]         o_ratio
);

    localparam int ENV_BITS = SAMPLE_BITS + pec_pkg::ENV_GUARD;
    localparam int MUL_W = ENV_BITS + COEFF_BITS;

    logic [SAMPLE_BITS-2:0]          r_thr;
    logic [pec_pkg::RATIO_BITS-1:0]  r_ratio;
    logic [COEFF_BITS-1:0]           r_attack;
    logic [COEFF_BITS-1:0]           r_release;
    logic [ENV_BITS-1:0]             r_env;
    logic [ENV_BITS-1:0]             n_env;

    logic [SAMPLE_BITS-1:0]          mag;
    logic [ENV_BITS-1:0]             mag_e;
    logic                            rising;
    logic [ENV_BITS-1:0]             diff;
    logic [COEFF_BITS-1:0]           coeff;
    logic [MUL_W-1:0]                prod;
    logic [ENV_BITS-1:0]             delta;
    logic [SAMPLE_BITS-2:0]          thr;

    always_comb begin
        mag    = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;
        mag_e  = {mag, {pec_pkg::ENV_GUARD{1'b0}}};
        rising = (mag_e > r_env);
        diff   = rising ? (mag_e - r_env) : (r_env - mag_e);
        coeff  = rising ? r_attack : r_release;
        prod   = MUL_W'(coeff) * MUL_W'(diff) + MUL_W'(1) * (MUL_W'(1) << (COEFF_BITS - 1));
        delta  = ENV_BITS'(prod >> COEFF_BITS);
        n_env  = rising ? (r_env + delta) : (r_env - delta);
        thr    = (r_thr == '0) ? (SAMPLE_BITS - 1)'(1) : r_thr;
    end

    assign o_thr_e  = {1'b0, thr, {pec_pkg::ENV_GUARD{1'b0}}};
    assign o_env    = n_env;
    assign o_ratio  = r_ratio;
    assign o_bypass = (n_env <= o_thr_e)
                   || (r_ratio <= pec_pkg::RATIO_BITS'(pec_pkg::RATIO_ONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= (SAMPLE_BITS - 1)'(pec_pkg::RST_THRESHOLD);
            r_ratio   <= pec_pkg::RATIO_BITS'(pec_pkg::RST_RATIO);
            r_attack  <= COEFF_BITS'(pec_pkg::RST_ATTACK);
            r_release <= COEFF_BITS'(pec_pkg::RST_RELEASE);
            r_env     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (pec_pkg::t_cfg_idx'(i_cfg_idx))
                    pec_pkg::CFG_THRESHOLD: r_thr <= i_cfg_data[SAMPLE_BITS-2:0];
                    pec_pkg::CFG_RATIO:     r_ratio <= i_cfg_data[pec_pkg::RATIO_BITS-1:0];
                    pec_pkg::CFG_ATTACK:    r_attack <= i_cfg_data[COEFF_BITS-1:0];
                    pec_pkg::CFG_RELEASE:   r_release <= i_cfg_data[COEFF_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                r_env <= n_env;
            end
        end
    end

endmodule

// ----- src/pec_back.sv -----
module pec_back #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_mid_empty,
    input  logic                                      i_bypass,
    input  logic [SAMPLE_BITS+pec_pkg::ENV_GUARD-1:0] i_env,
    input  logic [SAMPLE_BITS-1:0]                    i_raw,
    input  logic [SAMPLE_BITS+pec_pkg::ENV_GUARD-1:0] i_thr_e,
    input  logic [pec_pkg::RATIO_BITS-1:0]            i_ratio,
    output logic                                      o_mid_pop,
    input  logic                                      i_out_full,
    output logic                                      o_out_wr,
    output logic [SAMPLE_BITS-1:0]                    o_out_data
);

    localparam int ENV_BITS = SAMPLE_BITS + pec_pkg::ENV_GUARD;
    localparam int NORM_W = (ENV_BITS > pec_pkg::MANT_W) ? ENV_BITS : pec_pkg::MANT_W;
    localparam int LP_W = $clog2(NORM_W);
    localparam int LW = LP_W + pec_pkg::LOG_FRAC;
    localparam int SH_W = LP_W + 1;
    localparam int F = pec_pkg::LOG_FRAC;
    localparam int M = pec_pkg::MANT_W;
    localparam int CW = pec_pkg::CONST_W;

    typedef enum logic [8:0] {
        ST_INIT  = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_NORM  = 9'b000000100,
        ST_LOG   = 9'b000001000,
        ST_EMUL  = 9'b000010000,
        ST_EXP   = 9'b000100000,
        ST_OMUL  = 9'b001000000,
        ST_ORND  = 9'b010000000,
        ST_WRITE = 9'b100000000
    } t_state;

    t_state                              r_state;
    logic [pec_pkg::SQRT_CNT_W-1:0]      r_it;
    logic [pec_pkg::CONST_IDX_W-1:0]     r_k;
    logic [pec_pkg::SQRT_W-1:0]          r_sv;
    logic [pec_pkg::SQRT_W-1:0]          r_sres;
    logic [pec_pkg::SQRT_W-1:0]          r_sbit;
    logic [CW-1:0]                       r_ctab [pec_pkg::NUM_CONST];
    logic [SAMPLE_BITS-1:0]              r_raw;
    logic [NORM_W-1:0]                   r_ne;
    logic [NORM_W-1:0]                   r_nt;
    logic [LP_W-1:0]                     r_pe;
    logic [LP_W-1:0]                     r_pt;
    logic [M-1:0]                        r_me;
    logic [M-1:0]                        r_mt;
    logic [F-1:0]                        r_fe;
    logic [F-1:0]                        r_ft;
    logic [pec_pkg::REM_W-1:0]           r_rem;
    logic [F-1:0]                        r_s;
    logic [pec_pkg::CONST_IDX_W-1:0]     r_cnt;
    logic [LW-1:0]                       r_e;
    logic [M-1:0]                        r_g;
    logic [pec_pkg::PROD_W-1:0]          r_prod;
    logic [SAMPLE_BITS-1:0]              r_q;

    logic [pec_pkg::SQRT_W-1:0]          sq_t;
    logic [pec_pkg::SQRT_W-1:0]          n_sv;
    logic [pec_pkg::SQRT_W-1:0]          n_sres;
    logic [2*M-1:0]                      sqr_e;
    logic [2*M-1:0]                      sqr_t;
    logic [M:0]                          sq_e;
    logic [M:0]                          sq_t2;
    logic [pec_pkg::REM_W-1:0]           rem_sh;
    logic [LW-1:0]                       le;
    logic [LW-1:0]                       lt;
    logic [LW-1:0]                       d;
    logic [LW+F-1:0]                     emul;
    logic [M+CW:0]                       gmul;
    logic [SH_W-1:0]                     sh;
    logic [pec_pkg::PROD_W-1:0]          rsum;
    logic [SAMPLE_BITS-1:0]              qmag;
    logic [SAMPLE_BITS-1:0]              mag;

    always_comb begin
        sq_t   = r_sres + r_sbit;
        if (r_sv >= sq_t) begin
            n_sv   = r_sv - sq_t;
            n_sres = (r_sres >> 1) + r_sbit;
        end else begin
            n_sv   = r_sv;
            n_sres = r_sres >> 1;
        end
        sqr_e  = (2*M)'(r_me) * (2*M)'(r_me);
        sqr_t  = (2*M)'(r_mt) * (2*M)'(r_mt);
        sq_e   = sqr_e[2*M-1:M-1];
        sq_t2  = sqr_t[2*M-1:M-1];
        rem_sh = r_rem << 1;
        le     = {r_pe, r_fe};
        lt     = {r_pt, r_ft};
        d      = (le > lt) ? (le - lt) : '0;
        emul   = (LW+F)'(d) * (LW+F)'(r_s) + (LW+F)'(1 << (F - 1));
        gmul   = (M+CW+1)'(r_g) * (M+CW+1)'(r_ctab[r_cnt]) + (M+CW+1)'(1 << (CW - 1));
        sh     = SH_W'(30) + SH_W'(r_e[LW-1:F]);
        rsum   = r_prod + (pec_pkg::PROD_W'(1) << (sh - 1'b1));
        qmag   = (sh >= SH_W'(63)) ? '0 : SAMPLE_BITS'(rsum >> sh);
        mag    = r_raw[SAMPLE_BITS-1] ? (~r_raw + 1'b1) : r_raw;
    end

    assign o_mid_pop  = (r_state == ST_IDLE) && !i_mid_empty;
    assign o_out_wr   = (r_state == ST_WRITE) && !i_out_full;
    assign o_out_data = r_q;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_INIT && r_it == '1) begin
            r_ctab[r_k] <= n_sres[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_it    <= '0;
            r_k     <= '0;
            r_sv    <= pec_pkg::SQRT_W'(1) << (2 * CW - 1);
            r_sres  <= '0;
            r_sbit  <= pec_pkg::SQRT_W'(1) << (pec_pkg::SQRT_W - 2);
        end else begin
            case (r_state)
                ST_INIT: begin
                    r_it <= r_it + 1'b1;
                    if (r_it == '1) begin
                        r_sv   <= pec_pkg::SQRT_W'(n_sres[CW-1:0]) << CW;
                        r_sres <= '0;
                        r_sbit <= pec_pkg::SQRT_W'(1) << (pec_pkg::SQRT_W - 2);
                        r_k    <= r_k + 1'b1;
                        if (r_k == '1) begin
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_sv   <= n_sv;
                        r_sres <= n_sres;
                        r_sbit <= r_sbit >> 2;
                    end
                end
                ST_IDLE: begin
                    if (!i_mid_empty) begin
                        r_raw <= i_raw;
                        r_ne  <= NORM_W'(i_env);
                        r_nt  <= NORM_W'(i_thr_e);
                        r_pe  <= LP_W'(NORM_W - 1);
                        r_pt  <= LP_W'(NORM_W - 1);
                        r_rem <= pec_pkg::REM_W'(i_ratio) - pec_pkg::REM_W'(pec_pkg::RATIO_ONE);
                        if (i_bypass) begin
                            r_q     <= i_raw;
                            r_state <= ST_WRITE;
                        end else begin
                            r_state <= ST_NORM;
                        end
                    end
                end
                ST_NORM: begin
                    if (!r_ne[NORM_W-1]) begin
                        r_ne <= r_ne << 1;
                        r_pe <= r_pe - 1'b1;
                    end
                    if (!r_nt[NORM_W-1]) begin
                        r_nt <= r_nt << 1;
                        r_pt <= r_pt - 1'b1;
                    end
                    if (r_ne[NORM_W-1] && r_nt[NORM_W-1]) begin
                        r_me    <= r_ne[NORM_W-1 -: M];
                        r_mt    <= r_nt[NORM_W-1 -: M];
                        r_fe    <= '0;
                        r_ft    <= '0;
                        r_s     <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_LOG;
                    end
                end
                ST_LOG: begin
                    r_fe <= {r_fe[F-2:0], sq_e[M]};
                    r_me <= sq_e[M] ? sq_e[M:1] : sq_e[M-1:0];
                    r_ft <= {r_ft[F-2:0], sq_t2[M]};
                    r_mt <= sq_t2[M] ? sq_t2[M:1] : sq_t2[M-1:0];
                    if (rem_sh >= pec_pkg::REM_W'(i_ratio)) begin
                        r_rem <= rem_sh - pec_pkg::REM_W'(i_ratio);
                        r_s   <= {r_s[F-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_s   <= {r_s[F-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == '1) begin
                        r_state <= ST_EMUL;
                    end
                end
                ST_EMUL: begin
                    r_e     <= LW'(emul >> F);
                    r_g     <= M'(1) << (M - 1);
                    r_cnt   <= '0;
                    r_state <= ST_EXP;
                end
                ST_EXP: begin
                    if (r_e[F - 1 - r_cnt]) begin
                        r_g <= M'(gmul >> CW);
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == '1) begin
                        r_state <= ST_OMUL;
                    end
                end
                ST_OMUL: begin
                    r_prod  <= pec_pkg::PROD_W'(mag) * pec_pkg::PROD_W'(r_g);
                    r_state <= ST_ORND;
                end
                ST_ORND: begin
                    r_q     <= r_raw[SAMPLE_BITS-1] ? (~qmag + 1'b1) : qmag;
                    r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    if (!i_out_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_INIT;
                end
            endcase
        end
    end

    a_wr_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_wr |-> !i_out_full)
        else $error("result written into a full queue");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mid_pop |=> (r_state == ST_WRITE || r_state == ST_NORM))
        else $error("item taken without starting work");

    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXP) |-> (r_g <= (M'(1) << (M - 1))))
        else $error("gain grew above one");

    a_round_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ORND) |=> (r_state == ST_WRITE))
        else $error("rounding step not followed by write");

endmodule

// ----- src/peak_envelope_compressor.sv -----
// A passed-through item goes from its accepting edge through the mid queue, the back IDLE
// and WRITE states and the output queue until empty goes low; a compressed item also runs
// the leading-one normalize (5 to 27 steps at SAMPLE_BITS 24), the 16-step log2 and slope
// loop, EMUL, the 16-step exp2 loop, OMUL and ORND. The back takes no new item until the
// last is written. Reset: synchronous active low; registers return to defaults, envelope
// to zero, and the exp2 constant table is rebuilt by a square-root pass before work starts.
module peak_envelope_compressor #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEFF_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pec_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [((SAMPLE_BITS-1 > COEFF_BITS) ? ((SAMPLE_BITS-1 > pec_pkg::RATIO_BITS)
                   ? SAMPLE_BITS-1 : pec_pkg::RATIO_BITS)
                   : ((COEFF_BITS > pec_pkg::RATIO_BITS) ? COEFF_BITS
                   : pec_pkg::RATIO_BITS))-1:0] i_cfg_data,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_in,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [SAMPLE_BITS-1:0]         o_sample_out
);

    localparam int ENV_BITS = SAMPLE_BITS + pec_pkg::ENV_GUARD;
    localparam int W1 = (SAMPLE_BITS - 1 > pec_pkg::RATIO_BITS) ? SAMPLE_BITS - 1
                                                                : pec_pkg::RATIO_BITS;
    localparam int CFG_W = (W1 > COEFF_BITS) ? W1 : COEFF_BITS;
    localparam int MID_W = 1 + ENV_BITS + SAMPLE_BITS;

    logic                           accept;
    logic                           f_bypass;
    logic [ENV_BITS-1:0]            f_env;
    logic [ENV_BITS-1:0]            thr_e;
    logic [pec_pkg::RATIO_BITS-1:0] ratio;
    logic [MID_W-1:0]               mid_in;
    logic [MID_W-1:0]               mid_out;
    logic                           mid_full;
    logic                           mid_empty;
    logic                           mid_pop;
    logic                           out_wr;
    logic                           out_full;
    logic [SAMPLE_BITS-1:0]         out_data;
    logic [SAMPLE_BITS-1:0]         res_data;

    assign accept = push && !mid_full;
    assign full   = mid_full;
    assign mid_in = {f_bypass, f_env, i_sample_in};

    pec_front #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COEFF_BITS(COEFF_BITS),
        .CFG_W(CFG_W)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_accept(accept),
        .i_sample(i_sample_in),
        .o_bypass(f_bypass),
        .o_env(f_env),
        .o_thr_e(thr_e),
        .o_ratio(ratio)
    );

    pec_fifo #(
        .WIDTH(MID_W)
    ) u_mid (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_wr(accept),
        .i_data(mid_in),
        .i_rd(mid_pop),
        .o_data(mid_out),
        .o_full(mid_full),
        .o_empty(mid_empty)
    );

    pec_back #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_mid_empty(mid_empty),
        .i_bypass(mid_out[MID_W-1]),
        .i_env(mid_out[MID_W-2:SAMPLE_BITS]),
        .i_raw(mid_out[SAMPLE_BITS-1:0]),
        .i_thr_e(thr_e),
        .i_ratio(ratio),
        .o_mid_pop(mid_pop),
        .i_out_full(out_full),
        .o_out_wr(out_wr),
        .o_out_data(out_data)
    );

    pec_fifo #(
        .WIDTH(SAMPLE_BITS)
    ) u_out (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_wr(out_wr),
        .i_data(out_data),
        .i_rd(pop),
        .o_data(res_data),
        .o_full(out_full),
        .o_empty(empty)
    );

    assign o_sample_out = res_data;

endmodule
